@@ hdl/qbpd_pkg.sv @@
// Shared types, command codes and the quadrature step table for the event decoder.
// No dependencies; every other file in the project imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qbpd_pkg;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_PIN_EVENT   = 2'd0;
	localparam cmd_t CMD_CLR_ENCODER = 2'd1;
	localparam cmd_t CMD_CLR_RAIN    = 2'd2;
	localparam cmd_t CMD_CLR_TANK    = 2'd3;

	localparam int FLAG_ENC_A  = 0;
	localparam int FLAG_ENC_B  = 1;
	localparam int FLAG_BUTTON = 2;
	localparam int FLAG_RAIN   = 3;
	localparam int FLAG_TANK   = 4;
	localparam int PIN_BUTTON  = 2;

	typedef logic [1:0]        ab_t;
	typedef logic signed [1:0] step_t;
	typedef logic signed [2:0] accum_t;
	typedef logic signed [3:0] accum_sum_t;
	typedef logic [31:0]       count_t;

	localparam accum_sum_t ACC_DETENT_POS = 4'sd4;
	localparam accum_sum_t ACC_DETENT_NEG = -4'sd4;

	// Next state of the encoder after one pin event.
	typedef struct packed {
		ab_t    ab;
		accum_t accum;
		step_t  step;
	} enc_upd_t;

	// x4 Gray-code direction; stationary and double-bit jumps give zero.
	function automatic step_t step_dir(input ab_t prev, input ab_t cur);
		step_t d;
		unique case ({prev, cur})
			4'b0001: d = -2'sd1;
			4'b0010: d =  2'sd1;
			4'b0100: d =  2'sd1;
			4'b0111: d = -2'sd1;
			4'b1000: d = -2'sd1;
			4'b1011: d =  2'sd1;
			4'b1101: d =  2'sd1;
			4'b1110: d = -2'sd1;
			default: d =  2'sd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ hdl/qbpd_in_if.sv @@
// Input channel of the event decoder: valid/ready plus one event item.
// Depends on qbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qbpd_in_if;
	import qbpd_pkg::*;

	logic       valid;
	logic       ready;
	cmd_t       cmd;
	logic [7:0] change_flags;
	logic [7:0] captured_pins;

	modport source (output valid, output cmd, output change_flags, output captured_pins,
		input ready);
	modport sink (input valid, input cmd, input change_flags, input captured_pins,
		output ready);
endinterface

`default_nettype wire

@@ hdl/qbpd_out_if.sv @@
// Result channel of the event decoder: valid/ready plus one result item.
// Depends on qbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qbpd_out_if;
	import qbpd_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [31:0] detent_count;
	step_t              detent_step;
	count_t             rain_count;
	count_t             tank_count;
	logic               button_down;
	logic               press_event;

	modport source (output valid, output detent_count, output detent_step,
		output rain_count, output tank_count, output button_down, output press_event,
		input ready);
	modport sink (input valid, input detent_count, input detent_step,
		input rain_count, input tank_count, input button_down, input press_event,
		output ready);
endinterface

`default_nettype wire

@@ hdl/qbpd_quad.sv @@
// Quadrature step decoder: next A/B pair, sub-detent accumulator and detent step.
// Combinational; depends on qbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbpd_quad (
	input  wire logic              enable,
	input  wire qbpd_pkg::ab_t     prev_ab,
	input  wire qbpd_pkg::ab_t     cur_ab,
	input  wire qbpd_pkg::accum_t  accum,
	output qbpd_pkg::enc_upd_t     upd
);
	import qbpd_pkg::*;

	step_t      dir;
	accum_sum_t sum;

	assign dir = step_dir(prev_ab, cur_ab);
	assign sum = accum_sum_t'(accum) + accum_sum_t'(dir);

	always_comb begin
		upd.ab    = prev_ab;
		upd.accum = accum;
		upd.step  = 2'sd0;
		if (enable && (cur_ab != prev_ab)) begin
			upd.ab = cur_ab;
			if (dir != 2'sd0) begin
				priority if (sum == ACC_DETENT_POS) begin
					upd.accum = 3'sd0;
					upd.step  = 2'sd1;
				end else if (sum == ACC_DETENT_NEG) begin
					upd.accum = 3'sd0;
					upd.step  = -2'sd1;
				end else begin
					// hold the partial count between detents
					upd.accum = sum[2:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/quadrature_button_pulse_event_decoder.sv @@
// Top level of the quadrature, push-button and pulse-counter event decoder.
// Depends on qbpd_pkg, qbpd_in_if, qbpd_out_if and qbpd_quad.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one item per clock: a pin-change event (change flags plus captured
// pin levels) or a clear command, and returns exactly one result item for
// each. An accepted item is held in an input register; when the result slot
// is free, the decode and counter update run in a single pass and land in the
// result register, from which the result is offered. The block sustains one
// item per cycle as long as the sink takes results. The result register is
// the state itself (detent count, rain and tank counts, button level) plus
// the per-item detent step and press pulse; a stalled result holds the input
// register, and in_ch.ready falls only when both are full and the sink is
// not ready. The press notification enable, written through cfg_we/cfg_wdata,
// resets to disabled; the user must write it only while the block is idle,
// which the block itself does not enforce. Encoder A/B are decoded as x4
// Gray code; four steps in one direction move the detent count by one. All
// counters wrap modulo 2^32.

module quadrature_button_pulse_event_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	qbpd_in_if.sink   in_ch,
	qbpd_out_if.source out_ch
);
	import qbpd_pkg::*;

	// Configuration
	logic notify_en_q;

	// Input register stage
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] flags_s1;
	logic [7:0] pins_s1;

	// Encoder and button state, also the result register
	ab_t                prev_ab_q;
	accum_t             accum_q;
	logic signed [31:0] detent_total_q;
	count_t             rain_q;
	count_t             tank_q;
	logic               button_q;
	step_t              step_q;
	logic               press_q;
	logic               out_valid_q;

	logic     advance;
	logic     pin_event;
	logic     button_now;
	enc_upd_t enc_upd;

	// Move the held item into the result register when the result slot is free.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign pin_event  = (cmd_s1 == CMD_PIN_EVENT);
	assign button_now = ~pins_s1[PIN_BUTTON];

	qbpd_quad u_quad (
		.enable  (pin_event && (flags_s1[FLAG_ENC_A] || flags_s1[FLAG_ENC_B])),
		.prev_ab (prev_ab_q),
		.cur_ab  (pins_s1[1:0]),
		.accum   (accum_q),
		.upd     (enc_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notify_en_q <= 1'b0;
		end else if (cfg_we) begin
			notify_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload of the input stage needs no reset.
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1   <= in_ch.cmd;
			flags_s1 <= in_ch.change_flags;
			pins_s1  <= in_ch.captured_pins;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Architectural state: cleared by reset, advanced once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q      <= '0;
			accum_q        <= '0;
			detent_total_q <= '0;
			rain_q         <= '0;
			tank_q         <= '0;
			button_q       <= 1'b0;
			step_q         <= '0;
			press_q        <= 1'b0;
		end else if (advance) begin
			step_q  <= 2'sd0;
			press_q <= 1'b0;
			unique case (cmd_s1)
				CMD_PIN_EVENT: begin
					prev_ab_q      <= enc_upd.ab;
					accum_q        <= enc_upd.accum;
					step_q         <= enc_upd.step;
					detent_total_q <= detent_total_q + {{30{enc_upd.step[1]}}, enc_upd.step};
					if (flags_s1[FLAG_BUTTON]) begin
						// press pulse only on a released-to-pressed edge
						press_q  <= button_now && !button_q && notify_en_q;
						button_q <= button_now;
					end
					if (flags_s1[FLAG_RAIN]) begin
						rain_q <= rain_q + 32'd1;
					end
					if (flags_s1[FLAG_TANK]) begin
						tank_q <= tank_q + 32'd1;
					end
				end
				CMD_CLR_ENCODER: begin
					// drop count and partial steps, keep the last A/B pair
					detent_total_q <= '0;
					accum_q        <= '0;
				end
				CMD_CLR_RAIN: begin
					rain_q <= '0;
				end
				CMD_CLR_TANK: begin
					tank_q <= '0;
				end
				default: begin
					tank_q <= tank_q;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.detent_count = detent_total_q;
	assign out_ch.detent_step  = step_q;
	assign out_ch.rain_count   = rain_q;
	assign out_ch.tank_count   = tank_q;
	assign out_ch.button_down  = button_q;
	assign out_ch.press_event  = press_q;

endmodule

`default_nettype wire
